// File: hw/rtl/wc_pkg.sv
package wc_pkg;

    // Byte codes that steer the word and line scan.
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;

    localparam int OUT_BITS = 32;

    // Scan position within the text.
    typedef enum logic [2:0] {
        MODE_WORD = 3'b001,
        MODE_GAP  = 3'b010,
        MODE_CR   = 3'b100
    } scan_mode_t;

    // One accepted request held in the input stage.
    typedef struct packed {
        logic       valid;
        logic       end_of_text;
        logic [7:0] text_byte;
    } stage_t;

    // One set of counts on its way to the result side.
    typedef struct packed {
        logic [OUT_BITS-1:0] char_count;
        logic [OUT_BITS-1:0] word_count;
        logic [OUT_BITS-1:0] line_count;
    } result_t;

endpackage

// File: hw/rtl/text_line_word_char_counter.sv
// Timing: a taken byte request is held in the input register and then updates the running counts;
// the counts for an end-of-text request pass from the input register into the result queue and
// then appear on m_tvalid; the request waits in the input register while both result entries are full.
// Throughput: one request per cycle while no end of text waits for room in the result queue; the two-entry
// result queue lets bytes keep flowing while a result waits to be taken.
// Reset: aresetn is synchronous and active low; it clears all counts and both stages.
module text_line_word_char_counter #(
    parameter int COUNT_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic        s_tlast,   // end_of_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata    // [31:0] line_count, [63:32] word_count, [95:64] char_count
);

    wc_pkg::stage_t  stage;
    wc_pkg::result_t core_result;
    wc_pkg::result_t queue_result;
    logic            fire;
    logic            push;
    logic            queue_full;

    // The input register holds one request; it moves on every cycle except when
    // it is an end of text and the result queue has no room.
    wc_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_last    (s_tlast),
        .in_byte    (s_tdata),
        .queue_full (queue_full),
        .in_ready   (s_tready),
        .fire       (fire),
        .stage      (stage)
    );

    // The running counts and scan position; an end of text hands the counts
    // over and clears them in the same cycle.
    wc_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .stage   (stage),
        .push    (push),
        .result  (core_result)
    );

    // The result register with a skid entry behind it.
    wc_out_queue u_out_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (core_result),
        .full      (queue_full),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (queue_result)
    );

    assign m_tdata = {queue_result.char_count, queue_result.word_count,
                      queue_result.line_count};

endmodule

// File: hw/rtl/wc_in_stage.sv
module wc_in_stage (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    input  logic            in_last,
    input  logic [7:0]      in_byte,
    input  logic            queue_full,
    output logic            in_ready,
    output logic            fire,
    output wc_pkg::stage_t  stage
);

    wc_pkg::stage_t stage_reg;
    logic           advance;

    // A held byte always moves on; a held end of text needs room for its result.
    assign advance  = !stage_reg.valid || !stage_reg.end_of_text || !queue_full;
    assign in_ready = advance;
    assign fire     = stage_reg.valid && advance;
    assign stage    = stage_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg.valid <= 1'b0;
        end else if (advance) begin
            stage_reg.valid <= in_valid;
        end
        if (advance) begin
            stage_reg.end_of_text <= in_last;
            stage_reg.text_byte   <= in_byte;
        end
    end

endmodule

// File: hw/rtl/wc_core.sv
module wc_core #(
    parameter int COUNT_BITS = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             fire,
    input  wc_pkg::stage_t   stage,
    output logic             push,
    output wc_pkg::result_t  result
);

    localparam int OB = wc_pkg::OUT_BITS;

    wc_pkg::scan_mode_t      mode_reg, mode_next;
    logic [COUNT_BITS-1:0]   lines_reg, lines_next;
    logic [COUNT_BITS-1:0]   words_reg, words_next;
    logic [COUNT_BITS-1:0]   chars_reg, chars_next;
    logic [COUNT_BITS-1:0]   lines_inc, words_inc, chars_inc;
    logic [COUNT_BITS-1:0]   lines_final;
    logic                    after_cr;

    assign after_cr  = (mode_reg == wc_pkg::MODE_CR);
    assign lines_inc = (&lines_reg) ? lines_reg : lines_reg + COUNT_BITS'(1);
    assign words_inc = (&words_reg) ? words_reg : words_reg + COUNT_BITS'(1);
    assign chars_inc = (&chars_reg) ? chars_reg : chars_reg + COUNT_BITS'(1);

    // A CR still waiting for its line is counted at end of text.
    assign lines_final = after_cr ? lines_inc : lines_reg;
    assign push        = fire && stage.end_of_text;

    generate
        if (COUNT_BITS > OB) begin : g_clamp
            assign result.line_count = (|lines_final[COUNT_BITS-1:OB]) ? {OB{1'b1}}
                                                                       : lines_final[OB-1:0];
            assign result.word_count = (|words_reg[COUNT_BITS-1:OB]) ? {OB{1'b1}}
                                                                     : words_reg[OB-1:0];
            assign result.char_count = (|chars_reg[COUNT_BITS-1:OB]) ? {OB{1'b1}}
                                                                     : chars_reg[OB-1:0];
        end else begin : g_extend
            assign result.line_count = OB'(lines_final);
            assign result.word_count = OB'(words_reg);
            assign result.char_count = OB'(chars_reg);
        end
    endgenerate

    always_comb begin
        mode_next  = mode_reg;
        lines_next = lines_reg;
        words_next = words_reg;
        chars_next = chars_reg;
        if (fire) begin
            if (stage.end_of_text) begin
                mode_next  = wc_pkg::MODE_GAP;
                lines_next = '0;
                words_next = '0;
                chars_next = '0;
            end else begin
                chars_next = chars_inc;
                if (after_cr) begin
                    lines_next = lines_inc;
                end
                case (stage.text_byte)
                    wc_pkg::CHAR_SPACE, wc_pkg::CHAR_TAB: begin
                        mode_next = wc_pkg::MODE_GAP;
                    end
                    wc_pkg::CHAR_CR: begin
                        mode_next = wc_pkg::MODE_CR;
                    end
                    wc_pkg::CHAR_LF: begin
                        // After a CR the line was already counted above.
                        if (!after_cr) begin
                            lines_next = lines_inc;
                        end
                        mode_next = wc_pkg::MODE_GAP;
                    end
                    default: begin
                        if (mode_reg != wc_pkg::MODE_WORD) begin
                            words_next = words_inc;
                        end
                        mode_next = wc_pkg::MODE_WORD;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= wc_pkg::MODE_GAP;
            lines_reg <= '0;
            words_reg <= '0;
            chars_reg <= '0;
        end else begin
            mode_reg  <= mode_next;
            lines_reg <= lines_next;
            words_reg <= words_next;
            chars_reg <= chars_next;
        end
    end

endmodule

// File: hw/rtl/wc_out_queue.sv
module wc_out_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  wc_pkg::result_t  push_data,
    output logic             full,
    output logic             out_valid,
    input  logic             out_ready,
    output wc_pkg::result_t  out_data
);

    wc_pkg::result_t head_reg, skid_reg;
    logic [1:0]      count_reg, count_next;
    logic            pop;

    assign out_valid = (count_reg != 2'd0);
    assign full      = (count_reg == 2'd2);
    assign pop       = out_valid && out_ready;
    assign out_data  = head_reg;

    always_comb begin
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
        if (pop && count_reg == 2'd2) begin
            head_reg <= skid_reg;
        end
        if (push) begin
            if (count_reg == 2'd0 || pop) begin
                head_reg <= push_data;
            end else begin
                skid_reg <= push_data;
            end
        end
    end

endmodule

// File: hw/rtl/wc_checker.sv
module wc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata
);

    // Every line break is a byte that was counted, and so is every word start.
    a_lines_within_chars: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[31:0] <= m_tdata[95:64]))
        else $error("line count exceeds char count");

    a_words_within_chars: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[63:32] <= m_tdata[95:64]))
        else $error("word count exceeds char count");

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(m_tdata))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("result shown straight after reset");

endmodule

bind text_line_word_char_counter wc_checker u_wc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
